### rtl/aes128_block_cipher_assert.svh
// Assertion macros shared by the AES-128 checker.
// Depends on nothing; included by the checker file only.
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH
// Assert an implication that holds on every clock outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert an implication whose consequent is checked in the next cycle.
`define AES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/aes_pkg.sv
// Package for the AES-128 pipeline: S-box tables, GF(2^8) helpers, round types.
// Used by the key schedule, round stage and top level.
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow  = 2'd1;
  localparam logic [1:0] RegMode    = 2'd2;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   byte_t;

  // Control that travels with each word through the rounds
  typedef struct packed {
    logic valid;
    logic dec;
  } ctl_t;

  function automatic byte_t sbox_f(input byte_t a);
    byte_t t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic byte_t inv_sbox_f(input byte_t a);
    byte_t t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic byte_t rcon_f(input logic [3:0] r);
    byte_t v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic byte_t xt(input byte_t a);
    return a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
  endfunction

  // Byte i of the block sits at bits 127-8i downto 120-8i
  function automatic byte_t get_b(input blk_t s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // One forward or inverse round on a 128-bit state; key added last if forward
  function automatic blk_t round_f(input blk_t s, input blk_t k, input logic dec,
                                   input logic last);
    blk_t t, m;
    byte_t a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, e0, e1, e2, e3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (!dec)
          t[127-8*(r+4*c) -: 8] = sbox_f(get_b(s, r + 4*((c + r) & 3)));
        else
          t[127-8*(r+4*((c + r) & 3)) -: 8] = inv_sbox_f(get_b(s, r + 4*c));
      end
    end
    if (dec) t = t ^ k;
    m = t;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = get_b(t, 4*c); a1 = get_b(t, 4*c+1);
        a2 = get_b(t, 4*c+2); a3 = get_b(t, 4*c+3);
        x0 = xt(a0); x1 = xt(a1); x2 = xt(a2); x3 = xt(a3);
        y0 = xt(x0); y1 = xt(x1); y2 = xt(x2); y3 = xt(x3);
        e0 = xt(y0); e1 = xt(y1); e2 = xt(y2); e3 = xt(y3);
        if (!dec) begin
          m[127-8*(4*c)   -: 8] = x0 ^ (x1 ^ a1) ^ a2 ^ a3;
          m[127-8*(4*c+1) -: 8] = a0 ^ x1 ^ (x2 ^ a2) ^ a3;
          m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ x2 ^ (x3 ^ a3);
          m[127-8*(4*c+3) -: 8] = (x0 ^ a0) ^ a1 ^ a2 ^ x3;
        end else begin
          // 0e = 8^4^2, 0b = 8^2^1, 0d = 8^4^1, 09 = 8^1
          m[127-8*(4*c)   -: 8] = (e0^y0^x0) ^ (e1^x1^a1) ^ (e2^y2^a2) ^ (e3^a3);
          m[127-8*(4*c+1) -: 8] = (e0^a0) ^ (e1^y1^x1) ^ (e2^x2^a2) ^ (e3^y3^a3);
          m[127-8*(4*c+2) -: 8] = (e0^y0^a0) ^ (e1^a1) ^ (e2^y2^x2) ^ (e3^x3^a3);
          m[127-8*(4*c+3) -: 8] = (e0^x0^a0) ^ (e1^y1^a1) ^ (e2^a2) ^ (e3^y3^x3);
        end
      end
    end
    if (!dec) m = m ^ k;
    return m;
  endfunction

  // Next round key from the previous one
  function automatic blk_t key_next_f(input blk_t w, input logic [3:0] r);
    blk_t n;
    logic [31:0] t;
    t = {sbox_f(w[23:16]) ^ rcon_f(r), sbox_f(w[15:8]), sbox_f(w[7:0]), sbox_f(w[31:24])};
    n[127:96] = w[127:96] ^ t;
    n[95:64]  = w[95:64] ^ n[127:96];
    n[63:32]  = w[63:32] ^ n[95:64];
    n[31:0]   = w[31:0] ^ n[63:32];
    return n;
  endfunction

endpackage

### rtl/aes_key_sched.sv
// Round key schedule: expands the configured key into eleven round keys.
// Depends on aes_pkg. After each key write the keys ripple through the registered chain.
module aes_key_sched import aes_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  blk_t key,
  output blk_t rk [NumRounds+1]
);

  blk_t rk_r [NumRounds+1];

  // Chain of round keys, one registered step per round
  always_ff @(posedge clk) begin
    rk_r[0] <= key;
    for (int i = 1; i <= NumRounds; i++) begin
      rk_r[i] <= key_next_f(rk_r[i-1], 4'(i));
    end
  end

  assign rk = rk_r;

  // rst_n unused by payload-only registers; kept for a uniform port list
  logic unused_rst;
  assign unused_rst = rst_n;

endmodule

### rtl/aes_round_stage.sv
// One pipelined AES round, forward or inverse, with its registered valid/mode control.
// Depends on aes_pkg.
module aes_round_stage import aes_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic last,
  input  ctl_t ctl_in,
  input  blk_t st_in,
  input  blk_t key_in,
  output ctl_t ctl_out,
  output blk_t st_out
);

  ctl_t ctl_r;
  blk_t st_r;

  // Advance the word when the pipe moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_in;
    end
    if (adv) begin
      st_r <= round_f(st_in, key_in, ctl_in.dec, last);
    end
  end

  assign ctl_out = ctl_r;
  assign st_out  = st_r;

endmodule

### rtl/aes128_block_cipher.sv
// AES-128 ECB pipeline: one block per cycle through a key add stage and 10 rounds.
// Throughput: one word per cycle; the whole pipe halts while out_stall holds a valid result.
// After reset or any register write the input stalls while the round keys settle.
// Reset (rst_n low, synchronous) zeroes key and mode and empties the pipe.
// Depends on aes_pkg, aes_key_sched, aes_round_stage.
module aes128_block_cipher import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low
);

  logic [63:0] key_high_r, key_low_r;
  logic        dec_r;
  logic [3:0]  settle_r;
  logic        keys_busy;
  blk_t        rk [NumRounds+1];
  logic        adv;
  ctl_t        ctl [NumRounds+2];
  blk_t        st  [NumRounds+2];
  ctl_t        ctl0_r;
  blk_t        st0_r;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      dec_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeyHigh: key_high_r <= cfg_data;
        RegKeyLow:  key_low_r  <= cfg_data;
        RegMode:    dec_r      <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Count down while the key schedule settles after reset or a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 4'(NumRounds + 1);
    end else if (cfg_we) begin
      settle_r <= 4'(NumRounds + 1);
    end else if (settle_r != 4'd0) begin
      settle_r <= settle_r - 4'd1;
    end
  end

  assign keys_busy = (settle_r != 4'd0);

  aes_key_sched u_ks (.clk(clk), .rst_n(rst_n), .key({key_high_r, key_low_r}), .rk(rk));

  // Pipe moves whenever the output is not held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv || keys_busy;

  // Initial key add stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (adv) begin
      ctl0_r <= '{valid: in_valid && !keys_busy, dec: dec_r};
    end
    if (adv) begin
      st0_r <= {in_block_high, in_block_low} ^ (dec_r ? rk[NumRounds] : rk[0]);
    end
  end

  assign ctl[0] = ctl0_r;
  assign st[0]  = st0_r;

  // Ten round stages
  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round_stage u_rs (
      .clk(clk), .rst_n(rst_n), .adv(adv), .last(g == NumRounds),
      .ctl_in(ctl[g-1]), .st_in(st[g-1]),
      .key_in(ctl[g-1].dec ? rk[NumRounds-g] : rk[g]),
      .ctl_out(ctl[g]), .st_out(st[g])
    );
  end

  assign ctl[NumRounds+1] = ctl[NumRounds];
  assign st[NumRounds+1]  = st[NumRounds];

  assign out_valid       = ctl[NumRounds+1].valid;
  assign out_result_high = st[NumRounds+1][127:64];
  assign out_result_low  = st[NumRounds+1][63:0];

endmodule

### rtl/aes128_block_cipher_chk.sv
// Port-level checker for the AES-128 pipeline, bound to the top level.
// Depends on aes128_block_cipher_assert.svh.
`include "aes128_block_cipher_assert.svh"
module aes128_block_cipher_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_result_high,
  input logic [63:0] out_result_low
);
  // A held result always stalls the input
  `AES_ASSERT_IMP(a_stall_cause, clk, rst_n, out_valid && out_stall, in_stall)
  // Held result does not change
  `AES_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_result_high) && $stable(out_result_low))
  // Handshake outputs are always known outside reset
  `AES_ASSERT_IMP(a_known, clk, rst_n, 1'b1, !$isunknown({in_stall, out_valid}))
  logic unused;
  assign unused = in_valid;
endmodule

bind aes128_block_cipher aes128_block_cipher_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_result_high(out_result_high), .out_result_low(out_result_low)
);

### sim/aes128_cipher_checker.sv
`timescale 1ns / 1ps
// Checker for the AES-128 ECB pipeline: watches config, input and result words.
// Predicts each result from its own AES model and compares it in order.
module aes128_cipher_checker import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_result_high,
  input  logic [63:0] out_result_low,
  output int          fail_count,
  output int          pending,
  output int          words_checked
);

  logic [7:0]   sb [256];
  logic [7:0]   inv_sb [256];
  logic [7:0]   sched [176];
  logic [127:0] expected_blocks [$];
  logic [63:0]  key_hi, key_lo;
  logic         dec_mode;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) p ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // Build the S-box from field inverses and the affine map
  initial begin
    logic [7:0] inv, x;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++)
        if (gmul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sb[a] = x;
      inv_sb[x] = a[7:0];
    end
  end

  // Expand the held key into eleven round keys
  function automatic void expand_key();
    logic [7:0] t [4];
    logic [7:0] rc;
    for (int i = 0; i < 8; i++) begin
      sched[i]     = key_hi[63-8*i -: 8];
      sched[8 + i] = key_lo[63-8*i -: 8];
    end
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = sched[i-4+j];
      if ((i % 16) == 0) begin
        t = '{sb[sched[i-3]] ^ rc, sb[sched[i-2]], sb[sched[i-1]], sb[sched[i-4]]};
        rc = rc[7] ? ((rc << 1) ^ 8'h1b) : (rc << 1);
      end
      for (int j = 0; j < 4; j++) sched[i+j] = sched[i-16+j] ^ t[j];
    end
  endfunction

  function automatic logic [127:0] round_key(input int n);
    logic [127:0] k;
    for (int i = 0; i < 16; i++) k[127-8*i -: 8] = sched[16*n + i];
    return k;
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input bit inverse);
    logic [127:0] t;
    for (int i = 0; i < 16; i++)
      t[127-8*i -: 8] = inverse ? inv_sb[byte_at(s, i)] : sb[byte_at(s, i)];
    return t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input bit inverse);
    logic [127:0] t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (inverse) t[127-8*(r+4*((c+r)%4)) -: 8] = byte_at(s, r + 4*c);
        else         t[127-8*(r+4*c) -: 8] = byte_at(s, r + 4*((c+r)%4));
      end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inverse);
    logic [7:0]   m [4];
    logic [7:0]   v;
    logic [127:0] t;
    if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else         m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gmul(byte_at(s, 4*c + k), m[(k - r + 4) % 4]);
        t[127-8*(4*c+r) -: 8] = v;
      end
    return t;
  endfunction

  // Full block encryption or decryption under the current key
  function automatic logic [127:0] cipher_block(input logic [127:0] din, input bit dec);
    logic [127:0] s;
    expand_key();
    if (!dec) begin
      s = din ^ round_key(0);
      for (int rnd = 1; rnd <= 10; rnd++) begin
        s = shift_rows(sub_bytes(s, 1'b0), 1'b0);
        if (rnd < 10) s = mix_columns(s, 1'b0);
        s ^= round_key(rnd);
      end
    end else begin
      s = din ^ round_key(10);
      for (int rnd = 9; rnd >= 0; rnd--) begin
        s = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ round_key(rnd);
        if (rnd > 0) s = mix_columns(s, 1'b1);
      end
    end
    return s;
  endfunction

  always @(posedge clk) begin
    logic [127:0] want, got;
    if (!rst_n) begin
      key_hi = '0;
      key_lo = '0;
      dec_mode = 1'b0;
      expected_blocks.delete();
      fail_count = 0;
      words_checked = 0;
    end else begin
      // track register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          RegKeyHigh: key_hi = cfg_data;
          RegKeyLow:  key_lo = cfg_data;
          RegMode:    dec_mode = cfg_data[0];
          default: ;
        endcase
      end
      // predict each accepted input word
      if (in_valid && !in_stall)
        expected_blocks.push_back(cipher_block({in_block_high, in_block_low}, dec_mode));
      // compare each accepted result word with the oldest prediction
      if (out_valid && !out_stall) begin
        got = {out_result_high, out_result_low};
        words_checked++;
        if (expected_blocks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: unexpected result word %h", got);
        end else begin
          want = expected_blocks.pop_front();
          if (got[127:64] != want[127:64] || got[63:0] != want[63:0]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: result high/low got %h %h, expected %h %h",
                       got[127:64], got[63:0], want[127:64], want[63:0]);
          end
        end
      end
    end
    pending = expected_blocks.size();
  end

endmodule

### sim/tb_aes128_block_cipher.sv
`timescale 1ns / 1ps
// Top of the AES-128 ECB testbench: clock, reset, stimulus and verdict.
// Depends on aes_pkg, the block and aes128_cipher_checker.
module tb_aes128_block_cipher;
  import aes_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam logic [63:0] ModeEncrypt = 64'd0;
  localparam logic [63:0] ModeDecrypt = 64'd1;
  localparam int CycleLimit = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [63:0] in_block_high = '0;
  logic [63:0] in_block_low = '0;
  logic        out_stall = 1'b0;
  logic        in_stall, out_valid;
  logic [63:0] out_result_high, out_result_low;
  int          fail_count, pending, words_checked;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycles = 0;
  int          words_sent = 0;

  always #10 clk = ~clk;

  aes128_block_cipher dut (.*);

  aes128_cipher_checker u_checker (.*);

  // stall the result side at random, or for a long stretch on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one word, with random idle cycles ahead of it, and wait until taken
  task automatic send_word(input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_block_high <= hi;
    in_block_low <= lo;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // drop valid and let every expected word come back, plus the pipe depth
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // close a burst of writes and give the key schedule time to settle
  task automatic end_writes();
    cfg_we <= 1'b0;
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero key after reset, encrypt
    send_word('0, '0);
    send_word('1, '1);
    drain();
    // known-answer block
    write_reg(RegKeyHigh, 64'h0001020304050607);
    write_reg(RegKeyLow, 64'h08090a0b0c0d0e0f);
    end_writes();
    send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_word('0, '0);
    send_word('1, '1);
    drain();
    // wide mode value selects decryption from bit 0 only
    write_reg(RegMode, '1);
    end_writes();
    send_word(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_word('0, '0);
    send_word('1, '1);
    drain();
    // write to an unused index must change nothing
    write_reg(RegUnused, '1);
    end_writes();
    send_word(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_word(64'h8000000000000000, 64'h0000000000000001);
    drain();
    // all-ones key, both directions; mode value with every bit but bit 0 set
    write_reg(RegKeyHigh, '1);
    write_reg(RegKeyLow, '1);
    write_reg(RegMode, 64'hfffffffffffffffe);
    end_writes();
    send_word('0, '0);
    send_word('1, '1);
    send_word(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    write_reg(RegMode, ModeDecrypt);
    end_writes();
    send_word('0, '0);
    send_word('1, '1);
    send_word(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    drain();

    // random: three idling phases, four key settings each
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 22 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        write_reg(RegKeyHigh, rand64());
        write_reg(RegKeyLow, rand64());
        write_reg(RegMode, ($urandom_range(0, 1) ? ModeDecrypt : ModeEncrypt)
                           | ({$urandom, $urandom} & 64'hfffffffffffffffe));
        end_writes();
        for (int n = 0; n < 95; n++) begin
          // long receiver hold while words keep coming
          if (n == 20 && seg == 1) hold_req = hold_req + 1;
          // pause the sender until every result is back
          if (n == 60 && seg == 2) drain();
          send_word(rand64(), rand64());
        end
        drain();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Sent %0d words and checked %0d results across keys, both directions,",
             words_sent, words_checked);
    $display("three stall patterns and a long output hold; mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
